// ===== sv/ssps_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types.
`default_nettype none
package ssps_pkg;

	localparam int TIME_WIDTH   = 32;
	localparam int PERIOD_WIDTH = 24;
	localparam int SLOW_W       = 24;
	localparam int WEIGHT_W     = 8;
	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int STAGE_W      = 3;
	localparam int PHASE_W      = 3;
	// 3 * (up + down) fits in weight width + 3 bits
	localparam int DIVISOR_W    = WEIGHT_W + 3;
	localparam int WAIT_W       = PERIOD_WIDTH + WEIGHT_W;
	localparam int LIMIT_CMP_W  = (PERIOD_WIDTH > SLOW_W) ? PERIOD_WIDTH : SLOW_W;
	localparam int ELAPSED_CMP_W = (TIME_WIDTH > WAIT_W) ? TIME_WIDTH : WAIT_W;
	localparam int CNT_W        = $clog2(PERIOD_WIDTH);

	localparam logic [SLOW_W-1:0]   SLOW_RESET   = SLOW_W'(1000000);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1);

	localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP_WEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_WEIGHT = 2'd2;

	typedef struct packed {
		logic load_in;
		logic check;
		logic div_step;
		logic mul;
		logic commit;
		logic slow_commit;
		logic out_load;
	} ssps_cmd_t;

	typedef struct packed {
		logic slow;
		logic div_last;
	} ssps_sts_t;

endpackage
`default_nettype wire

// ===== sv/six_step_phase_sequencer_unit.sv =====
// Top level of the six-step phase sequencer: controller plus datapath.
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------------
// in       | input     | in_valid/in_stall  | timestamp[31:0], rot_period[23:0]
// out      | output    | out_valid/out_stall| phase_a, phase_b, phase_c, stage_now, advanced
// cfg      | input     | cfg_we             | cfg_index[1:0], cfg_data[23:0]
//
// One input transaction at a time: accept, limit check, a restoring divide
// (one quotient bit per cycle), multiply, compare, then output load.
// A slow tick skips the divide, multiply and compare. The output register
// frees the input side: a new tick is taken while the last result waits on
// out_stall; out_stall only holds the block in the output-load step. Reset
// clears stage, phases and last time and sets the config to its defaults.
`default_nettype none
module six_step_phase_sequencer_unit
	import ssps_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write port
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data,
	// tick transactions in
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [TIME_WIDTH-1:0]   timestamp,
	input  wire logic [PERIOD_WIDTH-1:0] rot_period,
	// result transactions out
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         phase_a,
	output logic                         phase_b,
	output logic                         phase_c,
	output logic [STAGE_W-1:0]           stage_now,
	output logic                         advanced
);

	ssps_cmd_t cmd;
	ssps_sts_t sts;

	// sequencing: one state per step of the tick
	ssps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic, sequence state and the output register
	ssps_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.timestamp  (timestamp),
		.rot_period (rot_period),
		.cmd        (cmd),
		.sts        (sts),
		.phase_a    (phase_a),
		.phase_b    (phase_b),
		.phase_c    (phase_c),
		.stage_now  (stage_now),
		.advanced   (advanced)
	);

endmodule
`default_nettype wire

// ===== sv/ssps_ctrl.sv =====
// Sequencing state machine: accept, check, divide, multiply, compare, output.
`default_nettype none
module ssps_ctrl
	import ssps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire ssps_sts_t sts,
	output ssps_cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_DIV   = 6'b000100,
		S_MUL   = 6'b001000,
		S_CMP   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.slow) begin
					cmd.slow_commit = 1'b1;
					state_d         = S_OUT;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/ssps_dp.sv =====
// Datapath: config registers, restoring divider, wait multiply, stage state, output register.
`default_nettype none
module ssps_dp
	import ssps_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data,
	input  wire logic [TIME_WIDTH-1:0]   timestamp,
	input  wire logic [PERIOD_WIDTH-1:0] rot_period,
	input  wire ssps_cmd_t               cmd,
	output ssps_sts_t                    sts,
	output logic                         phase_a,
	output logic                         phase_b,
	output logic                         phase_c,
	output logic [STAGE_W-1:0]           stage_now,
	output logic                         advanced
);

	localparam logic [STAGE_W-1:0] ST_C_OFF = 3'd0;
	localparam logic [STAGE_W-1:0] ST_A_ON  = 3'd1;
	localparam logic [STAGE_W-1:0] ST_A_OFF = 3'd2;
	localparam logic [STAGE_W-1:0] ST_B_ON  = 3'd3;
	localparam logic [STAGE_W-1:0] ST_B_OFF = 3'd4;
	localparam logic [STAGE_W-1:0] ST_C_ON  = 3'd5;

	logic [SLOW_W-1:0]       slow_q;
	logic [WEIGHT_W-1:0]     up_q, down_q;
	logic [TIME_WIDTH-1:0]   ts_q, last_q, elapsed_q;
	logic [PERIOD_WIDTH-1:0] rot_q, quo_q;
	logic [DIVISOR_W-1:0]    divisor_q, rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [WAIT_W-1:0]       wait_q;
	logic [STAGE_W-1:0]      stage_q, stage_out_q;
	logic [PHASE_W-1:0]      phase_q, phase_out_q;
	logic                    adv_q, adv_out_q;

	logic [DIVISOR_W:0]      shifted;
	logic [DIVISOR_W+1:0]    trial;
	logic [PERIOD_WIDTH-1:0] slice;
	logic [WEIGHT_W-1:0]     weight;
	logic [DIVISOR_W-1:0]    divisor_d;
	logic                    go;
	logic [PHASE_W-1:0]      phase_next;
	logic [STAGE_W-1:0]      stage_next;

	// 3 * (up + down)
	assign divisor_d = (DIVISOR_W'(up_q) + DIVISOR_W'(down_q)) * DIVISOR_W'(3);

	assign shifted = {rem_q, quo_q[PERIOD_WIDTH-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};

	assign sts.slow     = LIMIT_CMP_W'(rot_q) > LIMIT_CMP_W'(slow_q);
	assign sts.div_last = (cnt_q == CNT_W'(PERIOD_WIDTH - 1));

	assign slice  = (divisor_q == '0) ? '0 : quo_q;
	assign weight = stage_q[0] ? up_q : down_q;
	assign go     = ELAPSED_CMP_W'(elapsed_q) > ELAPSED_CMP_W'(wait_q);

	always_comb begin
		phase_next = phase_q;
		stage_next = stage_q + STAGE_W'(1);
		case (stage_q)
			ST_C_OFF: phase_next[2] = 1'b0;
			ST_A_ON:  phase_next[0] = 1'b1;
			ST_A_OFF: phase_next[0] = 1'b0;
			ST_B_ON:  phase_next[1] = 1'b1;
			ST_B_OFF: phase_next[1] = 1'b0;
			ST_C_ON: begin
				phase_next[2] = 1'b1;
				stage_next    = ST_C_OFF;
			end
			default: begin
				phase_next[2] = 1'b1;
				stage_next    = ST_C_OFF;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q  <= SLOW_RESET;
			up_q    <= WEIGHT_RESET;
			down_q  <= WEIGHT_RESET;
			last_q  <= '0;
			stage_q <= ST_C_OFF;
			phase_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SLOW_LIMIT:  slow_q <= cfg_data[SLOW_W-1:0];
					REG_UP_WEIGHT:   up_q   <= cfg_data[WEIGHT_W-1:0];
					REG_DOWN_WEIGHT: down_q <= cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.slow_commit) begin
				last_q <= ts_q;
			end
			if (cmd.commit && go) begin
				last_q  <= ts_q;
				stage_q <= stage_next;
				phase_q <= phase_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ts_q      <= timestamp;
			rot_q     <= rot_period;
			quo_q     <= rot_period;
			rem_q     <= '0;
			cnt_q     <= '0;
			divisor_q <= divisor_d;
		end
		if (cmd.check) begin
			elapsed_q <= ts_q - last_q;
		end
		if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (!trial[DIVISOR_W+1]) begin
				rem_q <= trial[DIVISOR_W-1:0];
				quo_q <= {quo_q[PERIOD_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIVISOR_W-1:0];
				quo_q <= {quo_q[PERIOD_WIDTH-2:0], 1'b0};
			end
		end
		if (cmd.mul) begin
			wait_q <= WAIT_W'(slice) * WAIT_W'(weight);
		end
		if (cmd.slow_commit) begin
			adv_q <= 1'b0;
		end
		if (cmd.commit) begin
			adv_q <= go;
		end
		if (cmd.out_load) begin
			phase_out_q <= phase_q;
			stage_out_q <= stage_q;
			adv_out_q   <= adv_q;
		end
	end

	assign phase_a   = phase_out_q[0];
	assign phase_b   = phase_out_q[1];
	assign phase_c   = phase_out_q[2];
	assign stage_now = stage_out_q;
	assign advanced  = adv_out_q;

endmodule
`default_nettype wire

// ===== dv/six_step_phase_checker.sv =====
`timescale 1ns / 1ps
// Checker for the six-step phase sequencer: predicts each result and compares it.
module six_step_phase_checker
	import ssps_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data,
	input  wire logic                    in_valid,
	input  wire logic                    in_stall,
	input  wire logic [TIME_WIDTH-1:0]   timestamp,
	input  wire logic [PERIOD_WIDTH-1:0] rot_period,
	input  wire logic                    out_valid,
	input  wire logic                    out_stall,
	input  wire logic                    phase_a,
	input  wire logic                    phase_b,
	input  wire logic                    phase_c,
	input  wire logic [STAGE_W-1:0]      stage_now,
	input  wire logic                    advanced,
	input  wire logic                    end_check,
	output int                           fail_count,
	output int                           pending
);

	localparam int PRINT_CAP = 40;

	typedef enum logic [STAGE_W-1:0] {
		STAGE_C_OFF, STAGE_A_ON, STAGE_A_OFF, STAGE_B_ON, STAGE_B_OFF, STAGE_C_ON
	} stage_e;

	typedef struct packed {
		logic [PHASE_W-1:0] levels;   // bit 0 phase_a .. bit 2 phase_c
		logic [STAGE_W-1:0] stage;
		logic               moved;
	} commutation_t;

	logic [SLOW_W-1:0]     lim;
	logic [WEIGHT_W-1:0]   w_up;
	logic [WEIGHT_W-1:0]   w_down;
	stage_e                stage_q;
	logic [TIME_WIDTH-1:0] mark_time;
	logic [PHASE_W-1:0]    levels_q;
	bit                    flushed;

	commutation_t expected_steps[$];

	task automatic note_mismatch(input string msg);
		if (fail_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// Advance the predicted sequencer by one tick and queue what it should emit.
	task automatic predict_commutation(input logic [TIME_WIDTH-1:0] ts,
			input logic [PERIOD_WIDTH-1:0] rp);
		logic [DIVISOR_W-1:0]  divisor;
		logic [PERIOD_WIDTH-1:0] slice;
		logic [63:0]           hold_time;
		logic [TIME_WIDTH-1:0] elapsed;
		commutation_t          res;
		divisor = DIVISOR_W'(3) * (DIVISOR_W'(w_up) + DIVISOR_W'(w_down));
		res.moved = 1'b0;
		if (rp > lim) begin
			mark_time = ts;
		end else begin
			slice     = (divisor == '0) ? '0 : rp / divisor;
			hold_time = 64'(slice) * 64'(stage_q[0] ? w_up : w_down);
			elapsed   = ts - mark_time;
			if (64'(elapsed) > hold_time) begin
				case (stage_q)
					STAGE_C_OFF: levels_q[2] = 1'b0;
					STAGE_A_ON:  levels_q[0] = 1'b1;
					STAGE_A_OFF: levels_q[0] = 1'b0;
					STAGE_B_ON:  levels_q[1] = 1'b1;
					STAGE_B_OFF: levels_q[1] = 1'b0;
					default:     levels_q[2] = 1'b1;
				endcase
				mark_time = ts;
				stage_q   = (stage_q == STAGE_C_ON) ? STAGE_C_OFF : stage_e'(stage_q + 1'b1);
				res.moved = 1'b1;
			end
		end
		res.levels = levels_q;
		res.stage  = stage_q;
		expected_steps.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		commutation_t exp_res;
		if (!arst_n) begin
			lim        = SLOW_RESET;
			w_up       = WEIGHT_RESET;
			w_down     = WEIGHT_RESET;
			stage_q    = STAGE_C_OFF;
			mark_time  = '0;
			levels_q   = '0;
			flushed    = 1'b0;
			fail_count = 0;
			expected_steps.delete();
			pending   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SLOW_LIMIT:  lim    = cfg_data[SLOW_W-1:0];
					REG_UP_WEIGHT:   w_up   = cfg_data[WEIGHT_W-1:0];
					REG_DOWN_WEIGHT: w_down = cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_steps.size() == 0) begin
					note_mismatch("result transaction with nothing expected");
				end else begin
					exp_res = expected_steps.pop_front();
					if (phase_a !== exp_res.levels[0])
						note_mismatch($sformatf("phase_a %b, want %b", phase_a, exp_res.levels[0]));
					if (phase_b !== exp_res.levels[1])
						note_mismatch($sformatf("phase_b %b, want %b", phase_b, exp_res.levels[1]));
					if (phase_c !== exp_res.levels[2])
						note_mismatch($sformatf("phase_c %b, want %b", phase_c, exp_res.levels[2]));
					if (stage_now !== exp_res.stage)
						note_mismatch($sformatf("stage_now %0d, want %0d", stage_now, exp_res.stage));
					if (advanced !== exp_res.moved)
						note_mismatch($sformatf("advanced %b, want %b", advanced, exp_res.moved));
				end
			end
			if (in_valid && !in_stall)
				predict_commutation(timestamp, rot_period);
			if (end_check && !flushed) begin
				flushed = 1'b1;
				if (expected_steps.size() != 0)
					note_mismatch($sformatf("%0d results never arrived", expected_steps.size()));
			end
			pending <= expected_steps.size();
		end
	end

endmodule

// ===== dv/tb_six_step_phase_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the six-step phase sequencer: stimulus, receiver stalls and verdict.
module tb_six_step_phase_sequencer_unit;
	import ssps_pkg::*;

	// Index past the end of the register list: writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Longest legal quiet stretch is the receiver hold-off below plus one
	// tick's processing; take it many times over.
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int PRESSURE_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 64;
	localparam int PHASES          = 13;
	localparam int ITEMS_PER_PHASE = 150;

	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index  = '0;
	logic [CFG_W-1:0]        cfg_data   = '0;
	logic                    in_valid   = 1'b0;
	logic [TIME_WIDTH-1:0]   timestamp  = '0;
	logic [PERIOD_WIDTH-1:0] rot_period = '0;
	logic                    out_stall  = 1'b0;
	logic                    end_check  = 1'b0;
	logic                    in_stall;
	logic                    out_valid;
	logic                    phase_a;
	logic                    phase_b;
	logic                    phase_c;
	logic [STAGE_W-1:0]      stage_now;
	logic                    advanced;
	int                      fail_count;
	int                      pending;

	// Copies of what was written, used only to aim timestamps near the wait edges.
	logic [SLOW_W-1:0]       sh_slow = SLOW_RESET;
	logic [WEIGHT_W-1:0]     sh_up   = WEIGHT_RESET;
	logic [WEIGHT_W-1:0]     sh_down = WEIGHT_RESET;
	logic [TIME_WIDTH-1:0]   cur_time = '0;
	int                      burst_left = 8;
	bit                      pressure_req = 1'b0;
	int                      quiet_cycles = 0;

	six_step_phase_sequencer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.timestamp  (timestamp),
		.rot_period (rot_period),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.phase_a    (phase_a),
		.phase_b    (phase_b),
		.phase_c    (phase_c),
		.stage_now  (stage_now),
		.advanced   (advanced)
	);

	six_step_phase_checker commutation_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.timestamp  (timestamp),
		.rot_period (rot_period),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.phase_a    (phase_a),
		.phase_b    (phase_b),
		.phase_c    (phase_c),
		.stage_now  (stage_now),
		.advanced   (advanced),
		.end_check  (end_check),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One register write per call; the caller drops cfg_we after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_SLOW_LIMIT:  sh_slow = data[SLOW_W-1:0];
			REG_UP_WEIGHT:   sh_up   = data[WEIGHT_W-1:0];
			REG_DOWN_WEIGHT: sh_down = data[WEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	// Drop valid and wait until every queued result is out. Every tick yields a
	// result, so an empty queue means the block is idle. The first edge lets the
	// checker count a transaction accepted at the current edge.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Full register set, written only while idle. Weight data may carry junk in
	// the upper bits; the block keeps only the low byte.
	task automatic apply_config(input logic [CFG_W-1:0] slow, input logic [CFG_W-1:0] up_data,
			input logic [CFG_W-1:0] down_data, input bit junk);
		wait_idle();
		write_reg(REG_SLOW_LIMIT, slow);
		write_reg(REG_UP_WEIGHT, up_data);
		write_reg(REG_DOWN_WEIGHT, down_data);
		if (junk)
			write_reg(REG_UNUSED, CFG_W'($urandom()));
		cfg_we <= 1'b0;
	endtask

	// Offer one tick transaction and hold it until taken, then apply the burst
	// and gap pattern of the sender.
	task automatic send_tick(input logic [TIME_WIDTH-1:0] ts, input logic [PERIOD_WIDTH-1:0] rp);
		int gap;
		timestamp  <= ts;
		rot_period <= rp;
		in_valid   <= 1'b1;
		cur_time    = ts;
		do
			@(posedge clk);
		while (in_stall);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
	endtask

	// Random tick: mostly periods under the slow limit with timestamps stepped
	// to land on, just past, or short of the current wait; some noise on top.
	task automatic make_tick();
		logic [PERIOD_WIDTH-1:0] rp;
		logic [DIVISOR_W-1:0]    div;
		logic [PERIOD_WIDTH-1:0] sl;
		logic [TIME_WIDTH-1:0]   hold;
		logic [TIME_WIDTH-1:0]   stride;
		int                      pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			rp = PERIOD_WIDTH'($urandom_range(0, sh_slow));
		else if (pick < 80)
			rp = (sh_slow == '1 || $urandom_range(0, 1) == 0) ? sh_slow : sh_slow + 1'b1;
		else
			rp = PERIOD_WIDTH'($urandom());
		div  = DIVISOR_W'(3) * (DIVISOR_W'(sh_up) + DIVISOR_W'(sh_down));
		sl   = (div == '0) ? '0 : rp / div;
		hold = TIME_WIDTH'(sl) * TIME_WIDTH'(($urandom_range(0, 1) == 0) ? sh_up : sh_down);
		pick = $urandom_range(0, 99);
		if (pick < 30)
			stride = hold + 1'b1;
		else if (pick < 45)
			stride = hold;
		else if (pick < 70)
			stride = $urandom_range(0, hold);
		else if (pick < 85)
			stride = hold + $urandom_range(1, 1000);
		else if (pick < 95)
			stride = $urandom();
		else
			stride = '0;
		send_tick(cur_time + stride, rp);
	endtask

	// Receiver: stall modes of random length, plus one long hold-off on request
	// so the output register stays full and the block stalls its input.
	initial begin : receiver
		rx_mode_e mode;
		int       mode_left;
		int       hold_left;
		bit       pressure_served;
		mode            = RX_OPEN;
		mode_left       = 0;
		hold_left       = 0;
		pressure_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (pressure_req && !pressure_served) begin
				pressure_served = 1'b1;
				hold_left       = PRESSURE_CYCLES;
				out_stall      <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(5, 80);
				end
				mode_left--;
				case (mode)
					RX_OPEN:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:  out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// Watchdog: too long without any transaction on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		logic [TIME_WIDTH-1:0] base;
		int                    ph;
		int                    n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset: stage 0, last time 0, unit weights, default slow limit.
		send_tick(32'd0, 24'd0);             // zero elapsed vs zero wait: strict compare holds
		send_tick(32'd1, 24'd0);             // steps to stage 1
		send_tick(32'd2, 24'd6);             // slice 1, elapsed 1: not past the wait
		send_tick(32'd3, 24'd6);             // elapsed 2: steps, phase_a on
		send_tick(32'd5, 24'd1000000);       // period equal to the limit is not slow
		send_tick(32'd7, 24'd1000001);       // slow tick: only the time mark moves
		send_tick('1, '1);                   // slow, time mark at the top of the range
		send_tick(32'd1, 24'd6);             // elapsed wraps through zero
		for (n = 0; n < 6; n++)
			send_tick(32'd3 + 32'(2 * n), 24'd6);  // one full lap, back to stage 3

		// Largest weights and slow limit, weight data with junk upper bits.
		apply_config(24'hFFFFFF, 24'hA5A5FF, 24'h3C00FF, 1'b1);
		base = cur_time;
		send_tick(base + 32'd2796075, 24'hFFFFFF);   // exactly the wait: no step
		send_tick(base + 32'd2796076, 24'hFFFFFF);   // one past: steps

		// Both weights zero: divisor is zero, slice is zero. Slow limit zero.
		apply_config(24'h000000, 24'h000100, 24'h000200, 1'b1);
		send_tick(cur_time, 24'd0);
		send_tick(cur_time + 1'b1, 24'd0);
		send_tick(cur_time + 32'd5, 24'd1);

		// One weight zero: up stages wait nothing, down stages wait 5 slices.
		apply_config(24'hFFFFFF, 24'h000000, 24'h000005, 1'b1);
		send_tick(cur_time + 1'b1, 24'hFFFFFF);
		send_tick(cur_time + 32'd5592406, 24'hFFFFFF);
		send_tick(cur_time + 1'b1, 24'h800000);

		// Random phases, each under its own register setting.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_config(24'hFFFFFF, 24'h0000FF, 24'h0000FF, 1'b0);
				1: apply_config(24'h000000, CFG_W'($urandom_range(1, 255)),
						CFG_W'($urandom_range(1, 255)), 1'b1);
				2: apply_config(CFG_W'($urandom()), 24'h000000, 24'h000000, 1'b0);
				3: apply_config(CFG_W'(SLOW_RESET), 24'h000001, 24'h000001, 1'b1);
				default: begin
					case ($urandom_range(0, 4))
						0: apply_config(CFG_W'($urandom()), CFG_W'($urandom_range(1, 255)),
								CFG_W'($urandom_range(1, 255)), $urandom_range(0, 1));
						1: apply_config(CFG_W'($urandom_range(1, 5000)),
								CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(1, 4)),
								$urandom_range(0, 1));
						2: apply_config(CFG_W'($urandom()), 24'h000000,
								CFG_W'($urandom_range(1, 255)), $urandom_range(0, 1));
						3: apply_config(CFG_W'($urandom()), CFG_W'($urandom()),
								CFG_W'($urandom()), $urandom_range(0, 1));
						default: apply_config(24'hFFFFFF, 24'h000001, 24'h0000FF, 1'b1);
					endcase
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Mid-run: receiver holds off while the sender keeps offering.
				if (ph == 5 && n == 40) begin
					pressure_req = 1'b1;
					burst_left   = 50;
				end
				make_tick();
			end
		end

		// Drain, give stray results time to show, then close out the checker.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		end_check <= 1'b1;
		repeat (3) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
